@@ rtl/kfic_pkg.sv @@
package kfic_pkg;

  localparam int MAX_FRAMES  = 256;
  localparam int CACHE_DEPTH = 4096;

  localparam int FC_W  = $clog2(MAX_FRAMES) + 1;   // frame count, holds MAX_FRAMES
  localparam int KA_W  = $clog2(MAX_FRAMES);       // keyframe address
  localparam int SC_W  = $clog2(CACHE_DEPTH) + 1;  // sample count, holds CACHE_DEPTH
  localparam int CA_W  = $clog2(CACHE_DEPTH);      // cache address

  localparam int DUR_W = 33;                        // positive duration magnitude
  localparam int N_W   = 24;                        // raw sample total
  localparam int DVD_W = DUR_W + N_W;               // divider dividend / product width
  localparam int CNT_W = $clog2(DVD_W + 1);

  // item kinds
  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_APPEND  = 2'd1;
  localparam logic [1:0] KIND_REBUILD = 2'd2;
  localparam logic [1:0] KIND_QUERY   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FEW     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [15:0] FPS_RESET = 16'd7680;
  localparam logic [15:0] FPS_ONE   = 16'd256;

  // register indexes
  localparam logic REG_FPS = 1'b0;

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_RD_A      = 16'h0002,
    S_RD_B      = 16'h0004,
    S_RD_C      = 16'h0008,
    S_DUR       = 16'h0010,
    S_MUL_N     = 16'h0020,
    S_N         = 16'h0040,
    S_DIV_MOD   = 16'h0080,
    S_MUL_IDX   = 16'h0100,
    S_DIV_IDX   = 16'h0200,
    S_CACHE_RD  = 16'h0400,
    S_QOUT      = 16'h0800,
    S_DIV_DQ    = 16'h1000,
    S_SCAN_ADDR = 16'h2000,
    S_SCAN_CMP  = 16'h4000,
    S_WRITE     = 16'h8000
  } state_t;

endpackage

@@ rtl/keyframe_index_cache_lookup.sv @@
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+---------------------------------
// command   | kind, time_value, looping                 | beat when start && !busy
// result    | frame_index, status                       | one-cycle strobe on done
// config    | psel penable pwrite paddr pwdata prdata   | write when psel&penable&pwrite
//
// Clear and append finish without leaving idle; the result strobes on the next cycle.
// Rebuild and query first read three keyframes and run the shared multiplier.
// A query that is not clamped uses the shared 57-step restoring divider
// once, or twice when looping. Rebuild runs at most one division and then,
// per sample, passes S_SCAN_ADDR and S_SCAN_CMP per keyframe scanned and
// then S_WRITE once.
// Reset is synchronous and empties the track and cache. The result side
// cannot stall; busy holds off new commands while the sequencer runs.
module keyframe_index_cache_lookup import kfic_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [31:0] time_value,
  input  logic               looping,
  output logic               done,
  output logic [7:0]         frame_index,
  output logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_t state;

  logic [15:0]        fps;
  logic [FC_W-1:0]    frame_count;
  logic [SC_W-1:0]    sample_count;

  logic [1:0]         kind_q;
  logic               loop_r;
  logic signed [31:0] t_r;
  logic signed [31:0] start_t;
  logic signed [31:0] last_t;
  logic signed [31:0] prev_t;
  logic signed [33:0] dur;
  logic [N_W-1:0]     n_r;
  logic [DUR_W-1:0]   off;
  logic               neg;
  logic [1:0]         st_r;

  // rebuild walk
  logic [SC_W-1:0]    nc;
  logic [CA_W-1:0]    den_m1;
  logic [CA_W-1:0]    smp;
  logic [DUR_W-1:0]   q;
  logic [DUR_W-1:0]   dq;
  logic [CA_W-1:0]    r;
  logic [CA_W-1:0]    dr;
  logic [FC_W-1:0]    j;

  // shared divider
  logic [DVD_W-1:0]   div_quo;
  logic [DUR_W-1:0]   div_rem;
  logic [DUR_W-1:0]   div_den;
  logic [CNT_W-1:0]   div_cnt;

  // memories
  logic [31:0]        kt_mem [MAX_FRAMES];
  logic [31:0]        kt_rdata;
  logic [KA_W-1:0]    kt_raddr;
  logic [7:0]         cache_mem [CACHE_DEPTH];
  logic [7:0]         cache_rdata;
  logic               cache_we;
  logic [7:0]         cache_wdata;

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;

  // register readback
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_FPS) prdata = {16'd0, fps};
  end

  logic [15:0] fps_q;
  assign fps_q = (fps == 16'd0) ? FPS_ONE : fps;

  logic [FC_W-1:0] fc_m1, fc_m2;
  assign fc_m1 = frame_count - FC_W'(1);
  assign fc_m2 = frame_count - FC_W'(2);

  // shared multiplier, operands picked by state
  logic [DUR_W-1:0] mul_a;
  logic [N_W-1:0]   mul_b;
  logic [DVD_W-1:0] product;
  always_comb begin
    mul_a = off;
    mul_b = n_r;
    if (state == S_MUL_N) begin
      mul_a = (dur > 34'sd0) ? dur[DUR_W-1:0] : '0;
      mul_b = {{(N_W-16){1'b0}}, fps_q};
    end
  end
  assign product = DVD_W'(mul_a) * DVD_W'(mul_b);

  // one restoring divider step
  logic [DUR_W:0]   div_sh;
  logic [DUR_W+1:0] div_diff;
  logic [DUR_W-1:0] div_rem_step;
  logic             div_bit;
  always_comb begin
    div_sh   = {div_rem, div_quo[DVD_W-1]};
    div_diff = {1'b0, div_sh} - {2'b00, div_den};
    div_bit  = !div_diff[DUR_W+1];
    div_rem_step = div_bit ? div_diff[DUR_W-1:0] : div_sh[DUR_W-1:0];
  end

  // keyframe read address
  always_comb begin
    case (state)
      S_RD_A:      kt_raddr = '0;
      S_RD_B:      kt_raddr = fc_m1[KA_W-1:0];
      S_RD_C:      kt_raddr = fc_m2[KA_W-1:0];
      S_SCAN_ADDR: kt_raddr = KA_W'(j - FC_W'(1));
      default:     kt_raddr = '0;
    endcase
  end

  // sample time and query offsets
  logic signed [33:0] samp_t;
  logic signed [33:0] tms;
  logic [DUR_W-1:0]   tms_abs;
  assign samp_t  = 34'(start_t) + $signed({1'b0, q});
  assign tms     = 34'(t_r) - 34'(start_t);
  assign tms_abs = tms[33] ? DUR_W'(-tms) : tms[DUR_W-1:0];

  logic [SC_W-1:0] nc_sat;
  assign nc_sat = (n_r > N_W'(CACHE_DEPTH)) ? SC_W'(CACHE_DEPTH) : n_r[SC_W-1:0];

  logic [CA_W:0]   r_sum;
  assign r_sum = {1'b0, r} + {1'b0, dr};

  logic [FC_W-1:0] pick;
  assign pick = ((j - FC_W'(1)) > fc_m2) ? fc_m2 : (j - FC_W'(1));

  // keyframe store
  logic kt_we;
  assign kt_we = (state == S_IDLE) && start && (kind == KIND_APPEND) &&
                 (frame_count != FC_W'(MAX_FRAMES));
  always_ff @(posedge clk) begin
    if (kt_we) kt_mem[frame_count[KA_W-1:0]] <= time_value;
    kt_rdata <= kt_mem[kt_raddr];
  end

  // sample cache
  assign cache_we = (state == S_WRITE);
  always_ff @(posedge clk) begin
    if (cache_we) cache_mem[smp] <= cache_wdata;
    cache_rdata <= cache_mem[div_quo[CA_W-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fps          <= FPS_RESET;
      frame_count  <= '0;
      sample_count <= '0;
      done         <= 1'b0;
      frame_index  <= '0;
      status       <= ST_OK;
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite && paddr[2] == REG_FPS) fps <= pwdata[15:0];

      case (state)
        S_IDLE: begin
          if (start) begin
            kind_latch(kind);
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          start_t <= kt_rdata;
          state   <= S_RD_C;
        end
        S_RD_C: begin
          last_t <= kt_rdata;
          state  <= S_DUR;
        end
        S_DUR: begin
          prev_t <= kt_rdata;
          dur    <= 34'(last_t) - 34'(start_t);
          state  <= S_MUL_N;
        end
        S_MUL_N: begin
          n_r   <= product[N_W+23:24];
          state <= S_N;
        end
        S_N: begin
          if (loop_r && st_r == ST_OK && kind_q == KIND_QUERY) begin
            if (dur <= 34'sd0) begin
              finish(8'd0, ST_OUTSIDE);
            end else begin
              div_quo <= DVD_W'(tms_abs);
              div_rem <= '0;
              div_den <= dur[DUR_W-1:0];
              div_cnt <= CNT_W'(DVD_W);
              neg     <= tms[33];
              state   <= S_DIV_MOD;
            end
          end else if (kind_q == KIND_QUERY) begin
            if (t_r <= start_t) begin
              finish(8'd0, ST_OK);
            end else if (t_r >= prev_t) begin
              finish(fc_m2[7:0], ST_OK);
            end else if (dur <= 34'sd0) begin
              finish(8'd0, ST_OUTSIDE);
            end else begin
              off   <= tms[DUR_W-1:0];
              state <= S_MUL_IDX;
            end
          end else begin
            // rebuild
            st_r   <= (n_r > N_W'(CACHE_DEPTH)) ? ST_OUTSIDE : ST_OK;
            nc     <= nc_sat;
            den_m1 <= CA_W'(nc_sat - SC_W'(1));
            q      <= '0;
            r      <= '0;
            dq     <= '0;
            dr     <= '0;
            smp    <= '0;
            j      <= frame_count;
            if (nc_sat == '0) begin
              sample_count <= '0;
              finish(8'd0, (n_r > N_W'(CACHE_DEPTH)) ? ST_OUTSIDE : ST_OK);
            end else if (nc_sat == SC_W'(1)) begin
              state <= S_SCAN_ADDR;
            end else begin
              div_quo <= DVD_W'(dur[DUR_W-1:0]);
              div_rem <= '0;
              div_den <= DUR_W'(nc_sat - SC_W'(1));
              div_cnt <= CNT_W'(DVD_W);
              state   <= S_DIV_DQ;
            end
          end
        end
        S_DIV_MOD: begin
          if (div_cnt != '0) begin
            div_step();
          end else begin
            off   <= (neg && div_rem != '0) ? (div_den - div_rem) : div_rem;
            state <= S_MUL_IDX;
          end
        end
        S_MUL_IDX: begin
          div_quo <= product;
          div_rem <= '0;
          div_den <= dur[DUR_W-1:0];
          div_cnt <= CNT_W'(DVD_W);
          state   <= S_DIV_IDX;
        end
        S_DIV_IDX: begin
          if (div_cnt != '0) begin
            div_step();
          end else if (div_quo >= DVD_W'(sample_count)) begin
            finish(8'd0, ST_OUTSIDE);
          end else begin
            state <= S_CACHE_RD;
          end
        end
        S_CACHE_RD: state <= S_QOUT;
        S_QOUT: finish(cache_rdata, ST_OK);
        S_DIV_DQ: begin
          if (div_cnt != '0) begin
            div_step();
          end else begin
            dq    <= div_quo[DUR_W-1:0];
            dr    <= div_rem[CA_W-1:0];
            state <= S_SCAN_ADDR;
          end
        end
        S_SCAN_ADDR: begin
          if (j == '0) begin
            cache_wdata <= 8'd0;
            state       <= S_WRITE;
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (samp_t >= 34'($signed(kt_rdata))) begin
            cache_wdata <= pick[7:0];
            state       <= S_WRITE;
          end else begin
            j     <= j - FC_W'(1);
            state <= S_SCAN_ADDR;
          end
        end
        S_WRITE: begin
          // step the exact sample time: duration*i = q*(n-1) + r
          if (r_sum >= {1'b0, den_m1}) begin
            r <= CA_W'(r_sum - {1'b0, den_m1});
            q <= q + dq + DUR_W'(1);
          end else begin
            r <= r_sum[CA_W-1:0];
            q <= q + dq;
          end
          j <= frame_count;
          if (SC_W'(smp) == nc - SC_W'(1)) begin
            sample_count <= nc;
            finish(8'd0, st_r);
          end else begin
            smp   <= smp + CA_W'(1);
            state <= S_SCAN_ADDR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      kind_q <= kind;
      t_r    <= time_value;
      loop_r <= looping;
    end
  end

  // accept one command in idle
  task automatic kind_latch(input logic [1:0] k);
    case (k)
      KIND_CLEAR: begin
        frame_count  <= '0;
        sample_count <= '0;
        finish(8'd0, ST_OK);
      end
      KIND_APPEND: begin
        if (frame_count == FC_W'(MAX_FRAMES)) begin
          finish(8'd0, ST_FULL);
        end else begin
          frame_count <= frame_count + FC_W'(1);
          finish(8'd0, ST_OK);
        end
      end
      default: begin
        st_r <= ST_OK;
        if (frame_count < FC_W'(2)) begin
          finish(8'd0, ST_FEW);
        end else begin
          state <= S_RD_A;
        end
      end
    endcase
  endtask

  task automatic finish(input logic [7:0] idx, input logic [1:0] st);
    done        <= 1'b1;
    frame_index <= (st == ST_OK) ? idx : 8'd0;
    status      <= st;
    state       <= S_IDLE;
  endtask

  task automatic div_step();
    div_rem <= div_rem_step;
    div_quo <= {div_quo[DVD_W-2:0], div_bit};
    div_cnt <= div_cnt - CNT_W'(1);
  endtask

  // checks
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> frame_index == 8'd0)
    else $error("nonzero index on failing result");

  a_sc_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= SC_W'(CACHE_DEPTH))
    else $error("sample count beyond cache");

  a_fc_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= FC_W'(MAX_FRAMES))
    else $error("frame count beyond store");

  a_long_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind[1] && frame_count >= FC_W'(2)) |=> (busy && !done))
    else $error("rebuild or query did not enter the sequencer");

endmodule

@@ verif/kfic_lookup_checker.sv @@
`timescale 1ns / 1ps

module kfic_lookup_checker import kfic_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [31:0] time_value,
  input  logic               looping,
  input  logic               done,
  input  logic [7:0]         frame_index,
  input  logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 mismatches,
  output int                 pending
);

  // shadow copy of the track and sample cache
  logic signed [31:0] key_times [MAX_FRAMES];
  logic [7:0]         cache_idx [CACHE_DEPTH];
  int                 frame_cnt;
  int                 sample_cnt;
  logic [15:0]        fps_reg;

  logic [7:0] exp_index [$];
  logic [1:0] exp_status [$];

  function automatic longint samples_for(longint dur);
    longint rate;
    rate = (fps_reg == 16'd0) ? longint'(FPS_ONE) : longint'(fps_reg);
    if (dur <= 0) return 0;
    return (dur * rate) >>> 24;
  endfunction

  // rebuild the sample cache; returns the status
  function automatic logic [1:0] rebuild_cache();
    longint first, dur, n, ts;
    int     pick, last;
    logic [1:0] st;
    if (frame_cnt < 2) return ST_FEW;
    first = key_times[0];
    dur   = longint'(key_times[frame_cnt-1]) - first;
    n     = samples_for(dur);
    st    = ST_OK;
    if (n > CACHE_DEPTH) begin
      n  = CACHE_DEPTH;
      st = ST_OUTSIDE;
    end
    last = frame_cnt - 2;
    for (int i = 0; i < n; i++) begin
      ts = first;
      if (n > 1) ts = first + (dur * i) / (n - 1);
      pick = 0;
      for (int j = frame_cnt; j > 0; j--) begin
        if (ts >= longint'(key_times[j-1])) begin
          pick = (j - 1 > last) ? last : j - 1;
          break;
        end
      end
      cache_idx[i] = pick[7:0];
    end
    sample_cnt = int'(n);
    return st;
  endfunction

  // time lookup against the current track and cache
  function automatic void lookup_time(input longint t, input logic wrap,
                                      output logic [7:0] fi, output logic [1:0] st);
    longint first, dur, off, n, idx;
    int     sel;
    fi = 8'd0;
    st = ST_OK;
    if (frame_cnt < 2) begin
      st = ST_FEW;
      return;
    end
    first = key_times[0];
    dur   = longint'(key_times[frame_cnt-1]) - first;
    if (wrap) begin
      if (dur <= 0) begin
        st = ST_OUTSIDE;
        return;
      end
      off = (t - first) % dur;
      if (off < 0) off += dur;
    end else begin
      if (t <= first) return;
      if (t >= longint'(key_times[frame_cnt-2])) begin
        sel = frame_cnt - 2;
        fi  = sel[7:0];
        return;
      end
      if (dur <= 0) begin
        st = ST_OUTSIDE;
        return;
      end
      off = t - first;
    end
    n   = samples_for(dur);
    idx = (off * n) / dur;
    if (idx >= sample_cnt) begin
      st = ST_OUTSIDE;
      return;
    end
    fi = cache_idx[idx];
  endfunction

  function automatic void predict_result(input logic [1:0] k, input logic signed [31:0] t,
                                         input logic wrap,
                                         output logic [7:0] fi, output logic [1:0] st);
    fi = 8'd0;
    st = ST_OK;
    case (k)
      KIND_CLEAR: begin
        frame_cnt  = 0;
        sample_cnt = 0;
      end
      KIND_APPEND: begin
        if (frame_cnt >= MAX_FRAMES) st = ST_FULL;
        else begin
          key_times[frame_cnt] = t;
          frame_cnt++;
        end
      end
      KIND_REBUILD: st = rebuild_cache();
      default: lookup_time(longint'(t), wrap, fi, st);
    endcase
  endfunction

  always @(posedge clk) begin
    logic [7:0] fi, want_fi;
    logic [1:0] st, want_st;
    int         errs;
    errs = 0;
    if (rst) begin
      frame_cnt  = 0;
      sample_cnt = 0;
      fps_reg    <= FPS_RESET;
      mismatches <= 0;
      pending    <= 0;
    end else begin
      // result beat against oldest expectation
      if (done) begin
        if (exp_index.size() == 0) begin
          $display("%0t: result with nothing expected: index %0d status %0d",
                   $time, frame_index, status);
          errs++;
        end else begin
          want_fi = exp_index.pop_front();
          want_st = exp_status.pop_front();
          if (frame_index !== want_fi) begin
            $display("%0t: frame_index expected %0d actual %0d", $time, want_fi, frame_index);
            errs++;
          end
          if (status !== want_st) begin
            $display("%0t: status expected %0d actual %0d", $time, want_st, status);
            errs++;
          end
        end
      end
      // command beat
      if (start && !busy) begin
        predict_result(kind, time_value, looping, fi, st);
        exp_index.push_back(fi);
        exp_status.push_back(st);
      end
      // register write
      if (psel && penable && pwrite && pready && paddr[2] == REG_FPS) fps_reg <= pwdata[15:0];
      mismatches <= mismatches + errs;
      pending    <= exp_index.size();
    end
  end

endmodule

@@ verif/keyframe_index_cache_lookup_test.sv @@
`timescale 1ns / 1ps

module keyframe_index_cache_lookup_test import kfic_pkg::*;;

  localparam int CYCLE_LIMIT = 50_000_000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CALM_TAIL = 200;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         kind;
  logic signed [31:0] time_value;
  logic               looping;
  logic               done;
  logic [7:0]         frame_index;
  logic [1:0]         status;
  logic               psel, penable, pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 mismatches;
  int                 pending;
  int                 cycles;
  int                 items_sent;
  logic               calm;

  keyframe_index_cache_lookup u_top (
    .clk, .rst, .start, .busy, .kind, .time_value, .looping, .done,
    .frame_index, .status, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  kfic_lookup_checker u_check (
    .clk, .rst, .start, .busy, .kind, .time_value, .looping, .done,
    .frame_index, .status, .psel, .penable, .pwrite, .pready, .paddr,
    .pwdata, .mismatches, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("keyframe_index_cache_lookup_test: errors");
        $finish;
      end
    end
  end

  // one command beat; start stays high until the caller drops it
  task automatic send_cmd(input logic [1:0] k, input logic signed [31:0] t, input logic wrap);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    kind       <= k;
    time_value <= t;
    looping    <= wrap;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_fps(input logic [15:0] v);
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= {16'($urandom_range(0, 65535)), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // track session: clear, mostly ordered appends, usually a rebuild, queries around it
  task automatic track_session();
    logic signed [31:0] first, cur, span;
    int nf, nq;
    nf    = $urandom_range(2, 6);
    first = $urandom_range(0, 3) == 0 ? $urandom() : $signed($urandom_range(0, 400000)) - 200000;
    cur   = first;
    send_cmd(KIND_CLEAR, $urandom(), $urandom_range(0, 1));
    for (int i = 0; i < nf; i++) begin
      if ($urandom_range(0, 49) == 0) cur = $urandom();          // wild timestamp
      else if ($urandom_range(0, 9) == 0) cur = cur - $urandom_range(0, 20000);
      else if (i > 0) cur = cur + $urandom_range(0, 40000);
      send_cmd(KIND_APPEND, cur, $urandom_range(0, 1));
    end
    span = cur - first;
    if ($urandom_range(0, 7) != 0) send_cmd(KIND_REBUILD, $urandom(), $urandom_range(0, 1));
    nq = $urandom_range(2, 8);
    for (int i = 0; i < nq; i++) begin
      case ($urandom_range(0, 5))
        0:       send_cmd(KIND_QUERY, $urandom(), $urandom_range(0, 1));
        1:       send_cmd(KIND_QUERY, first - $urandom_range(0, 30000), $urandom_range(0, 1));
        2:       send_cmd(KIND_QUERY, cur + $urandom_range(0, 30000), $urandom_range(0, 1));
        default: send_cmd(KIND_QUERY, first + $urandom_range(0, span > 0 ? span : 1),
                          $urandom_range(0, 1));
      endcase
    end
    // occasional stray command
    if ($urandom_range(0, 4) == 0)
      send_cmd(2'($urandom_range(0, 3)), $urandom(), $urandom_range(0, 1));
  endtask

  initial begin
    logic [15:0] fps_plan [6];
    int phase;
    rst        = 1'b1;
    start      = 1'b0;
    kind       = KIND_CLEAR;
    time_value = '0;
    looping    = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    items_sent = 0;
    calm       = 1'b0;
    fps_plan   = '{16'd7680, 16'd0, 16'd65535, 16'd1, 16'd256, 16'd0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty track, single frame, zero duration, extremes
    send_cmd(KIND_QUERY, 32'sd0, 1'b0);
    send_cmd(KIND_REBUILD, 32'sd0, 1'b0);
    send_cmd(KIND_APPEND, 32'sd65536, 1'b0);
    send_cmd(KIND_QUERY, 32'sd65536, 1'b1);
    send_cmd(KIND_APPEND, 32'sd65536, 1'b0);
    send_cmd(KIND_REBUILD, 32'sd0, 1'b0);
    send_cmd(KIND_QUERY, 32'sd70000, 1'b1);
    send_cmd(KIND_QUERY, 32'sd100, 1'b0);
    send_cmd(KIND_QUERY, 32'sd65536, 1'b0);
    send_cmd(KIND_CLEAR, 32'sd0, 1'b0);
    send_cmd(KIND_APPEND, 32'h8000_0000, 1'b0);
    send_cmd(KIND_APPEND, 32'sd0, 1'b0);
    send_cmd(KIND_APPEND, 32'h7fff_ffff, 1'b1);
    send_cmd(KIND_REBUILD, 32'sd0, 1'b0);
    send_cmd(KIND_QUERY, 32'h8000_0000, 1'b1);
    send_cmd(KIND_QUERY, 32'h7fff_ffff, 1'b1);
    send_cmd(KIND_QUERY, 32'sd12345, 1'b0);
    send_cmd(KIND_QUERY, -32'sd1, 1'b1);
    send_cmd(KIND_CLEAR, 32'sd0, 1'b0);
    send_cmd(KIND_APPEND, 32'sd0, 1'b0);
    send_cmd(KIND_APPEND, 32'sd65536, 1'b0);
    send_cmd(KIND_REBUILD, 32'sd0, 1'b0);
    send_cmd(KIND_QUERY, 32'sd32768, 1'b0);
    send_cmd(KIND_QUERY, 32'sd98304, 1'b1);

    // full store: equal timestamps keep the rebuild short
    send_cmd(KIND_CLEAR, 32'sd0, 1'b0);
    for (int i = 0; i < MAX_FRAMES + 2; i++) send_cmd(KIND_APPEND, 32'sd500, 1'b0);
    send_cmd(KIND_REBUILD, 32'sd0, 1'b0);
    send_cmd(KIND_QUERY, 32'sd600, 1'b0);
    send_cmd(KIND_QUERY, 32'sd400, 1'b1);

    // random sessions across several sample rates
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= phase * (RANDOM_ITEMS / 7) && phase < 7) begin
        write_fps(phase < 6 ? fps_plan[phase] : 16'($urandom_range(0, 65535)));
        phase++;
      end
      calm = (items_sent > RANDOM_ITEMS - CALM_TAIL);
      track_session();
    end
    write_fps(FPS_RESET);
    track_session();

    wait_idle();
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("keyframe_index_cache_lookup_test: clean");
    else $display("keyframe_index_cache_lookup_test: errors");
    $finish;
  end

endmodule
